// File: hw/rtl/tdpt_pkg.sv
// Shared command and status types for the trial-division prime tester.
package tdpt_pkg;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;       // capture the candidate, set divisor to three
        logic div_start;  // begin a remainder calculation
        logic div_step;   // one restoring-division step
        logic next_div;   // advance to the next odd divisor
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic lt2;        // candidate below two
        logic lt4;        // candidate below four
        logic even;       // candidate is even
        logic sq_gt_n;    // square of divisor exceeds candidate
        logic div_last;   // final division step is being taken
        logic rem_zero;   // remainder is zero
    } t_dp_sts;

endpackage

// File: hw/rtl/tdpt_num_if.sv
// Input channel carrying one candidate number per item.
interface tdpt_num_if #(
    parameter int WIDTH = 32
);
    logic             valid;
    logic             ready;
    logic [WIDTH-1:0] number;

    modport source (output valid, output number, input ready);
    modport sink   (input valid, input number, output ready);
endinterface

// File: hw/rtl/tdpt_res_if.sv
// Output channel carrying one prime flag per item.
interface tdpt_res_if;
    logic valid;
    logic ready;
    logic is_prime;

    modport source (output valid, output is_prime, input ready);
    modport sink   (input valid, input is_prime, output ready);
endinterface

// File: hw/rtl/tdpt_datapath.sv
// Datapath: candidate, odd divisor with running square, bit-serial remainder unit.
module tdpt_datapath
    import tdpt_pkg::*;
#(
    parameter int WIDTH = 32
) (
    input  logic             i_clk,
    input  logic [WIDTH-1:0] i_number,
    input  t_dp_cmd          i_cmd,
    output t_dp_sts          o_sts
);

    // The divisor never exceeds a little over the square root of the candidate.
    localparam int DW = (WIDTH + 1) / 2 + 2;
    localparam int SW = WIDTH + 2;
    localparam int CW = $clog2(WIDTH);

    logic [WIDTH-1:0] r_n;
    logic [DW-1:0]    r_d;
    logic [SW-1:0]    r_sq;
    logic [WIDTH-1:0] r_shift;
    logic [DW-1:0]    r_rem;
    logic [CW-1:0]    r_cnt;

    logic [DW:0]      trial;
    logic             fits;

    assign trial = {r_rem, r_shift[WIDTH-1]};
    assign fits  = trial >= {1'b0, r_d};

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_n  <= i_number;
            r_d  <= DW'(3);
            r_sq <= SW'(9);
        end else if (i_cmd.next_div) begin
            // (d + 2)^2 = d^2 + 4d + 4
            r_d  <= r_d + DW'(2);
            r_sq <= r_sq + SW'({r_d, 2'b00}) + SW'(4);
        end

        if (i_cmd.div_start) begin
            r_shift <= r_n;
            r_rem   <= '0;
            r_cnt   <= CW'(WIDTH - 1);
        end else if (i_cmd.div_step) begin
            r_shift <= {r_shift[WIDTH-2:0], 1'b0};
            r_rem   <= fits ? DW'(trial - {1'b0, r_d}) : trial[DW-1:0];
            r_cnt   <= r_cnt - CW'(1);
        end
    end

    always_comb begin
        o_sts.lt2      = r_n[WIDTH-1:1] == '0;
        o_sts.lt4      = r_n[WIDTH-1:2] == '0;
        o_sts.even     = ~r_n[0];
        o_sts.sq_gt_n  = r_sq > {2'b00, r_n};
        o_sts.div_last = r_cnt == '0;
        o_sts.rem_zero = r_rem == '0;
    end

endmodule

// File: hw/rtl/tdpt_ctrl.sv
// Controller: sequences the divisor trials and holds the output register.
module tdpt_ctrl
    import tdpt_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_num_valid,
    output logic    o_num_ready,
    output logic    o_res_valid,
    input  logic    i_res_ready,
    output logic    o_res_bit,
    output t_dp_cmd o_cmd,
    input  t_dp_sts i_sts
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CLASSIFY,
        S_CHECK,
        S_DIV,
        S_EVAL,
        S_FINISH
    } t_state;

    t_state r_state;
    logic   r_result;
    logic   r_out_valid;
    logic   r_out_bit;
    logic   slot_free;

    assign o_num_ready = r_state == S_IDLE;
    assign o_res_valid = r_out_valid;
    assign o_res_bit   = r_out_bit;
    assign slot_free   = ~r_out_valid | i_res_ready;

    always_comb begin
        o_cmd           = '0;
        o_cmd.load      = (r_state == S_IDLE) && i_num_valid;
        o_cmd.div_start = (r_state == S_CHECK) && !i_sts.sq_gt_n;
        o_cmd.div_step  = r_state == S_DIV;
        o_cmd.next_div  = (r_state == S_EVAL) && !i_sts.rem_zero;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            // In the finish state the output register is handled below.
            if (r_out_valid && i_res_ready && r_state != S_FINISH) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_num_valid) begin
                        r_state <= S_CLASSIFY;
                    end
                end
                S_CLASSIFY: begin
                    priority if (i_sts.lt2) begin
                        r_result <= 1'b0;
                        r_state  <= S_FINISH;
                    end else if (i_sts.lt4) begin
                        r_result <= 1'b1;
                        r_state  <= S_FINISH;
                    end else if (i_sts.even) begin
                        r_result <= 1'b0;
                        r_state  <= S_FINISH;
                    end else begin
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    // No divisor up to the square root was found.
                    if (i_sts.sq_gt_n) begin
                        r_result <= 1'b1;
                        r_state  <= S_FINISH;
                    end else begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (i_sts.div_last) begin
                        r_state <= S_EVAL;
                    end
                end
                S_EVAL: begin
                    if (i_sts.rem_zero) begin
                        r_result <= 1'b0;
                        r_state  <= S_FINISH;
                    end else begin
                        r_state <= S_CHECK;
                    end
                end
                S_FINISH: begin
                    if (slot_free) begin
                        r_out_valid <= 1'b1;
                        r_out_bit   <= r_result;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// File: hw/rtl/trial_division_prime_test.sv
// Top level of the trial-division prime tester.
//
// Usage: each item on i_num carries an unsigned candidate of WIDTH bits;
// each item on o_res carries one flag, is_prime, set when the candidate is
// prime. Zero and one give zero, two and three give one. Exactly one result
// item leaves for every input item, in order.
//
// Timing: one item is worked on at a time. Trivial cases (below four or
// even) go from acceptance through the classify state to the finish state,
// which loads the result register, and the next item is taken back in idle.
// An odd candidate passes through the check, divide and evaluate states once
// for every odd divisor tried from three up to its square root, and leaves
// from evaluate when a divisor is found or from check when none is. The
// bit-serial remainder unit, one quotient bit per cycle, does the divide work;
// at WIDTH = 32 the worst case is some 32768 divisors.
//
// The result sits in an output register; a new item is accepted while it
// waits. If the receiver stalls, a finished result holds the controller
// until the register frees. Synchronous reset empties the output register
// and returns the controller to idle.
module trial_division_prime_test
    import tdpt_pkg::*;
#(
    parameter int WIDTH = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    tdpt_num_if.sink          i_num,
    tdpt_res_if.source        o_res
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    tdpt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_num_valid (i_num.valid),
        .o_num_ready (i_num.ready),
        .o_res_valid (o_res.valid),
        .i_res_ready (o_res.ready),
        .o_res_bit   (o_res.is_prime),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    tdpt_datapath #(
        .WIDTH (WIDTH)
    ) u_datapath (
        .i_clk    (i_clk),
        .i_number (i_num.number),
        .i_cmd    (cmd),
        .o_sts    (sts)
    );

endmodule

// File: tb/sv/tb_trial_division_prime_test.sv
// Testbench for the trial-division prime tester: directed corners, then random candidates.
module tb_trial_division_prime_test;
    import tdpt_pkg::*;

    localparam int          WIDTH       = 32;
    localparam int unsigned CYCLE_LIMIT = 4_000_000;
    localparam int unsigned DRAIN_TAIL  = 60;
    localparam int unsigned RANDOM_ITEMS = 80;
    localparam int unsigned SHOW_LIMIT  = 10;

    // Holds the expected prime flags in order and checks the returned ones.
    class prime_flag_book;
        bit          expected_flags[$];
        int unsigned noted;
        int unsigned checked;
        int unsigned primes_noted;
        int unsigned mismatches;

        function new();
            noted        = 0;
            checked      = 0;
            primes_noted = 0;
            mismatches   = 0;
        endfunction

        // Odd divisors from three while d*d <= n; the bound is kept as d <= n / d.
        function bit is_prime_number(bit [WIDTH-1:0] candidate);
            longint unsigned n;
            longint unsigned d;
            n = candidate;
            if (n < 2)
                return 1'b0;
            if (n < 4)
                return 1'b1;
            if (n % 2 == 0)
                return 1'b0;
            for (d = 3; d <= n / d; d += 2) begin
                if (n % d == 0)
                    return 1'b0;
            end
            return 1'b1;
        endfunction

        function void note_candidate(bit [WIDTH-1:0] candidate);
            bit flag;
            flag = is_prime_number(candidate);
            expected_flags.push_back(flag);
            noted++;
            if (flag)
                primes_noted++;
        endfunction

        function void check_flag(logic flag);
            bit wanted;
            checked++;
            if (expected_flags.size() == 0) begin
                mismatches++;
                if (mismatches <= SHOW_LIMIT)
                    $display("Result item with no candidate waiting: is_prime=%b", flag);
                return;
            end
            wanted = expected_flags.pop_front();
            if (flag !== wanted) begin
                mismatches++;
                if (mismatches <= SHOW_LIMIT)
                    $display("is_prime mismatch on result %0d: expected %b, got %b",
                             checked, wanted, flag);
            end
        endfunction

        function int unsigned pending();
            return expected_flags.size();
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    int unsigned cycle_count = 0;
    int unsigned stall_mode  = 0;
    logic [15:0] stall_pattern = 16'hFFFF;

    prime_flag_book flag_book = new();

    tdpt_num_if #(.WIDTH(WIDTH)) num_ch ();
    tdpt_res_if                  res_ch ();

    trial_division_prime_test #(
        .WIDTH (WIDTH)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_num   (num_ch),
        .o_res   (res_ch)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Zero, one, two, three, small squares, even values, primes near powers of two,
    // the square of a prime (divisor squared equal to the candidate) and both
    // all-zero and all-one words.
    bit [WIDTH-1:0] corner_values [22] = '{
        32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd5, 32'd7, 32'd9, 32'd15, 32'd25,
        32'd49, 32'd121, 32'd65521, 32'd65537, 32'd16777213, 32'd16752649,
        32'hFFFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFE, 32'h5555_5555,
        32'h7FFF_FFFE, 32'd4093
    };

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles with %0d flags outstanding.",
                     cycle_count, flag_book.pending());
            $display("tb_trial_division_prime_test NOT OK");
            $finish;
        end
    end

    // Receiver: switches between always ready, coin-toss stalls and a fixed pattern.
    always @(posedge i_clk) begin
        if (cycle_count % 256 == 255) begin
            stall_mode    <= $urandom_range(0, 2);
            stall_pattern <= 16'($urandom);
        end
        case (stall_mode)
            0:       res_ch.ready <= 1'b1;
            1:       res_ch.ready <= 1'($urandom_range(0, 1));
            default: res_ch.ready <= stall_pattern[cycle_count[3:0]];
        endcase
    end

    always @(posedge i_clk) begin
        if (i_rst_n && res_ch.valid && res_ch.ready)
            flag_book.check_flag(res_ch.is_prime);
    end

    // Presents one candidate until it is taken, then idles for the given cycles.
    task automatic send_candidate(input bit [WIDTH-1:0] candidate,
                                  input int unsigned idle_after);
        num_ch.valid  <= 1'b1;
        num_ch.number <= candidate;
        @(posedge i_clk);
        while (!num_ch.ready)
            @(posedge i_clk);
        flag_book.note_candidate(candidate);
        if (idle_after != 0) begin
            num_ch.valid <= 1'b0;
            repeat (idle_after) @(posedge i_clk);
        end
    endtask

    int unsigned burst_left = 0;

    // Bursts of random length; sometimes the next burst follows with no gap at all.
    function automatic int unsigned next_idle();
        if (burst_left > 0) begin
            burst_left--;
            return 0;
        end
        burst_left = $urandom_range(0, 7);
        if ($urandom_range(0, 3) == 0)
            return 0;
        return $urandom_range(1, 12);
    endfunction

    // Large candidates are built as a small odd factor times a random cofactor,
    // so the divisor search stops early and the run stays short.
    function automatic bit [WIDTH-1:0] random_candidate();
        int unsigned pick;
        int unsigned factor;
        pick = $urandom_range(0, 99);
        if (pick < 15)
            return $urandom_range(0, 1023);
        if (pick < 55)
            return $urandom_range(0, 65535);
        if (pick < 75)
            return $urandom_range(0, (1 << 18) - 1);
        factor = 2 * $urandom_range(1, 99) + 1;
        return factor * $urandom_range(1, 32'hFFFF_FFFF / factor);
    endfunction

    initial begin
        i_rst_n       = 1'b0;
        num_ch.valid  = 1'b0;
        num_ch.number = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (corner_values[i])
            send_candidate(corner_values[i], next_idle());
        repeat (RANDOM_ITEMS)
            send_candidate(random_candidate(), next_idle());
        num_ch.valid <= 1'b0;

        while (flag_book.pending() != 0)
            @(posedge i_clk);
        repeat (DRAIN_TAIL) @(posedge i_clk);

        $display("Tested %0d candidates (%0d prime), %0d flags returned, %0d cycles.",
                 flag_book.noted, flag_book.primes_noted, flag_book.checked, cycle_count);
        $display("Corners: zero, one, two, three, even, prime squares, all-zero and all-one.");
        if (flag_book.mismatches == 0 && flag_book.pending() == 0) begin
            $display("tb_trial_division_prime_test OK");
        end else begin
            $display("%0d mismatches, %0d flags still outstanding.",
                     flag_book.mismatches, flag_book.pending());
            $display("tb_trial_division_prime_test NOT OK");
        end
        $finish;
    end

endmodule
